FILE: rtl/spg_pkg.sv
package spg_pkg;

    localparam int TABLE_BITS    = 12;
    localparam int SAMPLE_BITS   = 24;
    localparam int QUARTER_BITS  = TABLE_BITS - 2;
    localparam int QUARTER_DEPTH = 1 << QUARTER_BITS;

    localparam int PHASE_BITS  = 32;
    localparam int COUNT_BITS  = 16;
    localparam int ENTRY_BITS  = 24;
    localparam int MAG_BITS    = ENTRY_BITS + 1;
    localparam int BASE_BITS   = MAG_BITS + 1;
    localparam int OUT_BITS    = 24;
    localparam int SAMPLE_SHIFT = 25;
    localparam int PROD_BITS   = (BASE_BITS + SAMPLE_BITS > SAMPLE_SHIFT + OUT_BITS)
                                 ? BASE_BITS + SAMPLE_BITS : SAMPLE_SHIFT + OUT_BITS;

    localparam logic [MAG_BITS-1:0] PEAK_MAG = MAG_BITS'(1) << ENTRY_BITS;

    // Configuration register map.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_FRAMES = 1'd1;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = 32'd42852281;
    localparam logic [COUNT_BITS-1:0] MAX_FRAMES_RESET = 16'd400;

    typedef logic [ENTRY_BITS-1:0] sine_rom_t [QUARTER_DEPTH];

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ENTRY_MAX   = 64'h0000_0000_00FF_FFFF;
    localparam int unsigned TAYLOR_DIV [8] = '{272, 210, 156, 110, 72, 42, 20, 6};

    // Quarter-wave sine in Q24, built at elaboration from a nested Taylor series in Q30.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t  rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int j = 0; j < QUARTER_DEPTH; j++)
        begin
            x  = (HALF_PI_Q30 * 64'(j)) >> QUARTER_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int k = 0; k < 8; k++)
            begin
                t = ONE_Q30 - (((x2 * t) >> 30) / 64'(TAYLOR_DIV[k]));
            end
            s = ((x * t) >> 30) >> 6;
            rom[j] = (s > ENTRY_MAX) ? ENTRY_MAX[ENTRY_BITS-1:0] : s[ENTRY_BITS-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/spg_if.sv
interface spg_req_if
    import spg_pkg::*;
    ;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface spg_frame_if
    import spg_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [OUT_BITS-1:0]   left_sample;
    logic [OUT_BITS-1:0]   right_sample;
    logic [COUNT_BITS-1:0] frame_index;
    logic                  last_of_period;

    modport source (output valid, output left_sample, output right_sample,
                    output frame_index, output last_of_period, input ready);
    modport sink (input valid, input left_sample, input right_sample,
                  input frame_index, input last_of_period, output ready);
endinterface

FILE: rtl/sine_period_generator.sv
// Sine oscillator by direct digital synthesis: every request yields one stereo frame carrying
// the offset sine sample of the current phase on both slots, its index within the period and
// a last flag set when the 32-bit phase carries past a full turn or max_frames is reached.
// A taken request is registered into stage A with the phase update, then the synchronous
// quarter-wave table read fills stage B and the scaling to 24 bits fills the output register. The
// pipeline takes a request every cycle and only stalls when the output register is full and
// not being taken. Write phase_step and max_frames only while no frame is in flight.
module sine_period_generator
    import spg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    spg_req_if.sink                   req,
    spg_frame_if.source               frame
);

    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [COUNT_BITS-1:0] max_frames_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // Stage A: table address and frame info.
    logic                    a_valid_reg;
    logic [QUARTER_BITS-1:0] a_addr_reg;
    logic                    a_peak_reg;
    logic                    a_neg_reg;
    logic [COUNT_BITS-1:0]   a_index_reg;
    logic                    a_last_reg;

    // Stage B: magnitude from the table.
    logic                    b_valid_reg;
    logic [MAG_BITS-1:0]     b_mag_reg;
    logic                    b_neg_reg;
    logic [COUNT_BITS-1:0]   b_index_reg;
    logic                    b_last_reg;

    // Output register.
    logic                    out_valid_reg;
    logic [OUT_BITS-1:0]     out_sample_reg;
    logic [COUNT_BITS-1:0]   out_index_reg;
    logic                    out_last_reg;

    logic                    advance;
    logic                    accept;
    logic [PHASE_BITS-1:0]   phase_cur;
    logic [COUNT_BITS-1:0]   count_cur;
    logic [TABLE_BITS-1:0]   table_addr;
    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] quarter_pos;
    logic [PHASE_BITS:0]     phase_sum;
    logic [COUNT_BITS:0]     count_sum;
    logic                    last;
    logic [PHASE_BITS-1:0]   phase_next;
    logic [COUNT_BITS-1:0]   count_next;
    logic [BASE_BITS-1:0]    base;
    logic [PROD_BITS-1:0]    scaled;

    assign advance   = !out_valid_reg || frame.ready;
    assign req.ready = advance;
    assign accept    = req.valid && advance;

    always_comb
    begin
        phase_cur   = req.restart ? '0 : phase_reg;
        count_cur   = req.restart ? '0 : count_reg;
        table_addr  = phase_cur[PHASE_BITS-1 -: TABLE_BITS];
        quad        = table_addr[TABLE_BITS-1 -: 2];
        quarter_pos = table_addr[QUARTER_BITS-1:0];
        phase_sum   = {1'b0, phase_cur} + {1'b0, phase_step_reg};
        count_sum   = {1'b0, count_cur} + (COUNT_BITS + 1)'(1);
        // A zero limit compares as always reached, so every frame ends the period.
        last        = phase_sum[PHASE_BITS] || (count_sum >= {1'b0, max_frames_reg});
        phase_next  = last ? '0 : phase_sum[PHASE_BITS-1:0];
        count_next  = last ? '0 : count_sum[COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RESET;
            max_frames_reg <= MAX_FRAMES_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[PHASE_BITS-1:0];
                CFG_MAX_FRAMES: max_frames_reg <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            count_reg     <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
            a_valid_reg   <= accept;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // Odd quadrants run the table backward; their first entry is the peak, one past the table.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_addr_reg  <= quad[0] ? (QUARTER_BITS'(0) - quarter_pos) : quarter_pos;
            a_peak_reg  <= quad[0] && (quarter_pos == '0);
            a_neg_reg   <= quad[1];
            a_index_reg <= count_cur;
            a_last_reg  <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_mag_reg   <= a_peak_reg ? PEAK_MAG : {1'b0, SINE_ROM[a_addr_reg]};
            b_neg_reg   <= a_neg_reg;
            b_index_reg <= a_index_reg;
            b_last_reg  <= a_last_reg;
        end
    end

    // Scaling by 2^SAMPLE_BITS - 1 is a shift and a subtract.
    always_comb
    begin
        base   = b_neg_reg ? ({1'b0, PEAK_MAG} - {1'b0, b_mag_reg})
                           : ({1'b0, PEAK_MAG} + {1'b0, b_mag_reg});
        scaled = (PROD_BITS'(base) << SAMPLE_BITS) - PROD_BITS'(base);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= scaled[SAMPLE_SHIFT +: OUT_BITS];
            out_index_reg  <= b_index_reg;
            out_last_reg   <= b_last_reg;
        end
    end

    assign frame.valid          = out_valid_reg;
    assign frame.left_sample    = out_sample_reg;
    assign frame.right_sample   = out_sample_reg;
    assign frame.frame_index    = out_index_reg;
    assign frame.last_of_period = out_last_reg;

endmodule
